@@ hw/rtl/rwa_pkg.sv @@
// Package for the rolling window average unit.
// Configuration register layout and reset constants; no dependencies.
package rwa_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int WIN_REG_W  = 7;

  // Register index, taken from the word address cfg_paddr[2].
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  localparam logic [WIN_REG_W-1:0] WIN_RESET = 7'd8;

endpackage

@@ hw/rtl/rolling_window_average_unit.sv @@
// Rolling window average: ring store of samples, running sum, serial divide.
// One sample at a time: in_tready is low from the input beat until its result
// is loaded for output. The divider produces one quotient bit per cycle.
// A pending output beat does not block the next input beat.
// Reset (sync, active low): window length 8, position, count and sum cleared;
// the sample store is not cleared. Uses rwa_pkg, rwa_store, rwa_div.
module rolling_window_average_unit
  import rwa_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata: sample [SAMPLE_BITS-1:0]
  input  logic                                            in_tvalid,
  output logic                                            in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]                in_tdata,
  // out_tdata: average [SAMPLE_BITS-1:0], samples_held above it
  output logic                                            out_tvalid,
  input  logic                                            out_tready,
  output logic [((SAMPLE_BITS+$clog2(MAX_WINDOW+1)+7)/8)*8-1:0] out_tdata,
  input  logic                                            cfg_psel,
  input  logic                                            cfg_penable,
  input  logic                                            cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]                           cfg_paddr,
  input  logic [CFG_DATA_W-1:0]                           cfg_pwdata,
  output logic [CFG_DATA_W-1:0]                           cfg_prdata,
  output logic                                            cfg_pready
);

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + PTR_W;
  localparam int OUT_W  = ((SAMPLE_BITS + CNT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV} state_t;

  state_t                  state_r, state_nxt;
  logic [WIN_REG_W-1:0]    win_len_r, win_len_nxt;
  logic [CNT_W-1:0]        win_eff_r, win_eff_nxt;
  logic [CNT_W-1:0]        win_wr;
  logic [PTR_W-1:0]        wpos_r, wpos_nxt;
  logic [PTR_W-1:0]        pos_r, pos_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_avg_r, out_avg_nxt;
  logic [CNT_W-1:0]        out_held_r, out_held_nxt;

  logic                    in_fire;
  logic                    cfg_wr;
  logic                    full;
  logic                    out_free;
  logic                    out_load;
  logic [PTR_W-1:0]        pos_eff;
  logic [CNT_W-1:0]        pos_inc;
  logic                    mem_we;
  logic [SAMPLE_BITS-1:0]  mem_rdata;
  logic                    div_start;
  logic                    div_done;
  logic signed [SAMPLE_BITS-1:0] div_quo;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[2] == REG_WINDOW_LENGTH);
  assign cfg_prdata = (cfg_paddr[2] == REG_WINDOW_LENGTH) ?
                      CFG_DATA_W'(win_len_r) : '0;

  // zero means a one-sample window; larger than the store saturates
  always_comb begin
    if (cfg_pwdata[WIN_REG_W-1:0] == '0) begin
      win_wr = CNT_W'(1);
    end else if (int'(cfg_pwdata[WIN_REG_W-1:0]) > MAX_WINDOW) begin
      win_wr = CNT_W'(MAX_WINDOW);
    end else begin
      win_wr = CNT_W'(cfg_pwdata[WIN_REG_W-1:0]);
    end
  end

  assign pos_eff   = (CNT_W'(wpos_r) >= win_eff_r) ? '0 : wpos_r;
  assign pos_inc   = CNT_W'(pos_r) + 1'b1;
  assign full      = fill_r >= win_eff_r;
  assign mem_we    = (state_r == S_READ);
  assign div_start = (state_r == S_READ);
  assign out_free  = !out_tvalid_r || out_tready;
  assign out_load  = (state_r == S_DIV) && div_done && out_free;

  always_comb begin
    state_nxt      = state_r;
    win_len_nxt    = win_len_r;
    win_eff_nxt    = win_eff_r;
    wpos_nxt       = wpos_r;
    pos_nxt        = pos_r;
    fill_nxt       = fill_r;
    sum_nxt        = sum_r;
    sample_nxt     = sample_r;
    out_tvalid_nxt = out_tvalid_r;
    out_avg_nxt    = out_avg_r;
    out_held_nxt   = out_held_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          sample_nxt = in_tdata[SAMPLE_BITS-1:0];
          pos_nxt    = pos_eff;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        // old entry is on mem_rdata; add new, drop old once the window is full
        if (full) begin
          sum_nxt = sum_r + SUM_W'(sample_r) - SUM_W'($signed(mem_rdata));
        end else begin
          sum_nxt  = sum_r + SUM_W'(sample_r);
          fill_nxt = fill_r + 1'b1;
        end
        wpos_nxt  = (pos_inc >= win_eff_r) ? '0 : pos_inc[PTR_W-1:0];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (out_load) begin
          out_tvalid_nxt = 1'b1;
          out_avg_nxt    = div_quo;
          out_held_nxt   = fill_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_wr) begin
      win_len_nxt = cfg_pwdata[WIN_REG_W-1:0];
      win_eff_nxt = win_wr;
      wpos_nxt    = '0;
      fill_nxt    = '0;
      sum_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      win_len_r    <= WIN_RESET;
      win_eff_r    <= (int'(WIN_RESET) > MAX_WINDOW) ? CNT_W'(MAX_WINDOW)
                                                     : CNT_W'(WIN_RESET);
      wpos_r       <= '0;
      fill_r       <= '0;
      sum_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      win_len_r    <= win_len_nxt;
      win_eff_r    <= win_eff_nxt;
      wpos_r       <= wpos_nxt;
      fill_r       <= fill_nxt;
      sum_r        <= sum_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    pos_r      <= pos_nxt;
    sample_r   <= sample_nxt;
    out_avg_r  <= out_avg_nxt;
    out_held_r <= out_held_nxt;
  end

  rwa_store #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (SAMPLE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (pos_r),
    .wdata (sample_r),
    .re    (in_fire),
    .raddr (pos_eff),
    .rdata (mem_rdata)
  );

  rwa_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W),
    .QUO_W (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (fill_nxt),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'({out_held_r, out_avg_r});

  a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win_eff_r)
    else $error("fill count beyond window length");

  a_wpos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(wpos_r) < win_eff_r)
    else $error("write position beyond window length");

  a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_done)
    else $error("divider reports done right after start");

  a_load_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (fill_r != '0) && !$past(in_fire))
    else $error("result loaded with empty window or without an update");

endmodule

@@ hw/rtl/rwa_store.sv @@
// Sample ring store: one write port, one read port, registered read data.
// No dependencies.
module rwa_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/rwa_div.sv @@
// Bit-serial signed divider: signed dividend by a nonzero unsigned divisor,
// quotient truncated toward zero, one quotient bit per cycle. No dependencies.
module rwa_div #(
  parameter int DVD_W = 22,
  parameter int DVS_W = 7,
  parameter int QUO_W = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0]        divisor,
  output logic                    done,
  output logic signed [QUO_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [DVD_W-1:0]  q_r, q_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_sub;
  logic              fits;
  logic [DVD_W-1:0]  q_signed;

  assign rem_sh  = {rem_r, q_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign fits    = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = STEP_W'(DVD_W);
      neg_nxt  = dividend[DVD_W-1];
      // magnitude fits unsigned even for the most negative dividend
      q_nxt    = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      q_nxt   = {q_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign q_signed = neg_r ? (~q_r + 1'b1) : q_r;
  assign quotient = QUO_W'(q_signed);
  assign done     = done_r;

endmodule
